// ----- rtl/tgs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tgs_pkg;

   localparam int NUM_STATES  = 16;
   localparam int NUM_SYMBOLS = 16;
   localparam int TAPE_COLS   = 256;
   localparam int TAPE_ROWS   = 256;

   localparam int STATE_W   = 4;
   localparam int SYM_W     = 4;
   localparam int COORD_W   = 8;
   localparam int SIZE_W    = 9;
   localparam int COUNT_W   = 16;
   localparam int TABLE_AW  = STATE_W + SYM_W;
   localparam int TAPE_AW   = 2 * COORD_W;
   localparam int TABLE_DEPTH = NUM_STATES * NUM_SYMBOLS;
   localparam int TAPE_DEPTH  = TAPE_COLS * TAPE_ROWS;

   localparam logic [SIZE_W-1:0] COLS_LIMIT = SIZE_W'(TAPE_COLS);
   localparam logic [SIZE_W-1:0] ROWS_LIMIT = SIZE_W'(TAPE_ROWS);

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_UP    = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_RUN  = 1'b1
   } action_type;

   typedef enum logic {
      CSR_TAPE_WIDTH  = 1'b0,
      CSR_TAPE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [STATE_W-1:0] next_state;
      logic [SYM_W-1:0]   write_symbol;
      dir_type            move_dir;
   } entry_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } head_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/turmite_grid_stepper.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Load transaction: result strobe in the cycle after start, next start accepted then.
// Run transaction: each step passes through S_LOOKUP and S_APPLY, a tape read followed
// by a table read, around the tape RAM loop; the strobe follows the last S_APPLY.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle per transaction.
// Reset: state 0, size 256x256, head at center; busy stays high while the tape RAM is
// swept to zero. Configuration writes are taken at any time.
module turmite_grid_stepper
   import tgs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_action,
   input  wire logic [STATE_W-1:0] req_entry_state,
   input  wire logic [SYM_W-1:0]   req_entry_symbol,
   input  wire logic [STATE_W-1:0] req_next_state,
   input  wire logic [SYM_W-1:0]   req_write_symbol,
   input  wire logic [1:0]         req_move_dir,
   input  wire logic [COUNT_W-1:0] req_step_count,
   output logic                    rsp_strobe,
   output logic [STATE_W-1:0]      rsp_machine_state,
   output logic [COORD_W-1:0]      rsp_head_x,
   output logic [COORD_W-1:0]      rsp_head_y,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [SIZE_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_LOOKUP = 4'b0100,
      S_APPLY  = 4'b1000
   } fsm_type;

   fsm_type             state_ff, state_in;
   logic [TAPE_AW-1:0]  clear_addr_ff, clear_addr_in;
   logic [COUNT_W-1:0]  remaining_ff, remaining_in;
   logic [STATE_W-1:0]  mstate_ff, mstate_in;
   head_type            head_ff, head_in;
   logic [SIZE_W-1:0]   width_ff, width_in;
   logic [SIZE_W-1:0]   height_ff, height_in;
   logic                fwd_ff, fwd_in;
   logic [SYM_W-1:0]    fwd_sym_ff, fwd_sym_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]  rsp_state_ff, rsp_state_in;
   head_type            rsp_head_ff, rsp_head_in;

   logic                accept;
   logic                csr_write;
   logic [SIZE_W-1:0]   csr_size;
   logic [SYM_W-1:0]    cur_sym;
   entry_type           entry;
   entry_type           load_entry;
   logic [ENTRY_W-1:0]  table_rdata;
   head_type            head_next;
   logic [TAPE_AW-1:0]  cur_addr;
   logic [TAPE_AW-1:0]  next_addr;

   logic                tape_wr_en;
   logic [TAPE_AW-1:0]  tape_wr_addr;
   logic [SYM_W-1:0]    tape_wr_data;
   logic                tape_rd_en;
   logic [TAPE_AW-1:0]  tape_rd_addr;
   logic [SYM_W-1:0]    tape_rdata;
   logic                table_wr_en;
   logic                table_rd_en;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_size  = clamp_size(csr_wdata, (csr_index == CSR_TAPE_WIDTH) ? COLS_LIMIT
                                                                          : ROWS_LIMIT);

   assign cur_addr  = {head_ff.row, head_ff.col};
   assign next_addr = {head_next.row, head_next.col};
   // take the symbol just written when the head lands on the same cell
   assign cur_sym   = fwd_ff ? fwd_sym_ff : tape_rdata;
   assign entry     = entry_type'(table_rdata);

   assign load_entry.next_state   = req_next_state;
   assign load_entry.write_symbol = req_write_symbol;
   assign load_entry.move_dir     = dir_type'(req_move_dir);

   tgs_head_move u_head_move (
      .head_cur    (head_ff),
      .tape_width  (width_ff),
      .tape_height (height_ff),
      .dir         (entry.move_dir),
      .head_next   (head_next)
   );

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      remaining_in  = remaining_ff;
      mstate_in     = mstate_ff;
      head_in       = head_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      fwd_in        = 1'b0;
      fwd_sym_in    = fwd_sym_ff;
      sym_in        = sym_ff;
      rsp_valid_in  = 1'b0;
      rsp_state_in  = rsp_state_ff;
      rsp_head_in   = rsp_head_ff;
      tape_wr_en    = 1'b0;
      tape_wr_addr  = cur_addr;
      tape_wr_data  = entry.write_symbol;
      tape_rd_en    = 1'b0;
      tape_rd_addr  = cur_addr;
      table_wr_en   = 1'b0;
      table_rd_en   = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            tape_wr_en    = 1'b1;
            tape_wr_addr  = clear_addr_ff;
            tape_wr_data  = '0;
            clear_addr_in = clear_addr_ff + TAPE_AW'(1);
            if (clear_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (action_type'(req_action) == ACT_RUN && req_step_count != '0) begin
                  tape_rd_en   = 1'b1;
                  remaining_in = req_step_count;
                  state_in     = S_LOOKUP;
               end else begin
                  table_wr_en  = (action_type'(req_action) == ACT_LOAD);
                  rsp_valid_in = 1'b1;
                  rsp_state_in = mstate_ff;
                  rsp_head_in  = head_ff;
               end
            end
         end
         S_LOOKUP: begin
            table_rd_en = 1'b1;
            sym_in      = cur_sym;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            tape_wr_en = 1'b1;
            mstate_in  = entry.next_state;
            head_in    = head_next;
            if (remaining_ff == COUNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = entry.next_state;
               rsp_head_in  = head_next;
               state_in     = S_IDLE;
            end else begin
               // issue the next step's tape read alongside this write
               tape_rd_en   = 1'b1;
               tape_rd_addr = next_addr;
               fwd_in       = (next_addr == cur_addr);
               fwd_sym_in   = entry.write_symbol;
               remaining_in = remaining_ff - COUNT_W'(1);
               state_in     = S_LOOKUP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write) begin
         if (csr_index == CSR_TAPE_WIDTH) begin
            width_in    = csr_size;
            head_in.col = csr_size[SIZE_W-1:1];
            head_in.row = height_ff[SIZE_W-1:1];
         end else begin
            height_in   = csr_size;
            head_in.col = width_ff[SIZE_W-1:1];
            head_in.row = csr_size[SIZE_W-1:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         remaining_ff  <= '0;
         mstate_ff     <= '0;
         head_ff.col   <= COLS_LIMIT[SIZE_W-1:1];
         head_ff.row   <= ROWS_LIMIT[SIZE_W-1:1];
         width_ff      <= COLS_LIMIT;
         height_ff     <= ROWS_LIMIT;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         remaining_ff  <= remaining_in;
         mstate_ff     <= mstate_in;
         head_ff       <= head_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_sym_ff   <= fwd_sym_in;
      sym_ff       <= sym_in;
      rsp_state_ff <= rsp_state_in;
      rsp_head_ff  <= rsp_head_in;
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_machine_state = rsp_state_ff;
   assign rsp_head_x        = rsp_head_ff.col;
   assign rsp_head_y        = rsp_head_ff.row;

   tgs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (table_wr_en),
      .wr_addr ({req_entry_state, req_entry_symbol}),
      .wr_data (load_entry),
      .rd_en   (table_rd_en),
      .rd_addr ({mstate_ff, cur_sym}),
      .rd_data (table_rdata)
   );

   tgs_ram #(
      .WIDTH (SYM_W),
      .DEPTH (TAPE_DEPTH)
   ) u_tape_ram (
      .clock   (clock),
      .wr_en   (tape_wr_en),
      .wr_addr (tape_wr_addr),
      .wr_data (tape_wr_data),
      .rd_en   (tape_rd_en),
      .rd_addr (tape_rd_addr),
      .rd_data (tape_rdata)
   );

   // sym_ff holds the symbol seen by the current step
   a_sym_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (sym_ff == $past(cur_sym)))
      else $error("looked-up symbol changed before apply");

   a_fwd_only_lookup: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (state_ff == S_LOOKUP))
      else $error("forwarding flag set outside lookup");

   a_no_tape_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> !tape_wr_en)
      else $error("tape write while a transaction is accepted");

   a_steps_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP || state_ff == S_APPLY) |-> (remaining_ff != '0))
      else $error("running with no steps left");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) || $past(state_ff == S_APPLY)))
      else $error("result strobe without a finished transaction");

endmodule

`default_nettype wire

// ----- rtl/tgs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tgs_head_move.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgs_head_move
   import tgs_pkg::*;
(
   input  wire head_type          head_cur,
   input  wire logic [SIZE_W-1:0] tape_width,
   input  wire logic [SIZE_W-1:0] tape_height,
   input  wire dir_type           dir,
   output head_type               head_next
);

   logic [SIZE_W-1:0] col_inc;
   logic [SIZE_W-1:0] row_inc;
   logic [SIZE_W-1:0] col_last;
   logic [SIZE_W-1:0] row_last;

   assign col_inc  = {1'b0, head_cur.col} + SIZE_W'(1);
   assign row_inc  = {1'b0, head_cur.row} + SIZE_W'(1);
   assign col_last = tape_width - SIZE_W'(1);
   assign row_last = tape_height - SIZE_W'(1);

   // wrap around the torus edges set by the size registers
   always_comb begin
      head_next = head_cur;
      case (dir)
         DIR_LEFT: begin
            head_next.col = (head_cur.col != '0) ? head_cur.col - COORD_W'(1)
                                                 : col_last[COORD_W-1:0];
         end
         DIR_UP: begin
            head_next.row = (head_cur.row != '0) ? head_cur.row - COORD_W'(1)
                                                 : row_last[COORD_W-1:0];
         end
         DIR_RIGHT: begin
            head_next.col = (col_inc < tape_width) ? col_inc[COORD_W-1:0] : '0;
         end
         DIR_DOWN: begin
            head_next.row = (row_inc < tape_height) ? row_inc[COORD_W-1:0] : '0;
         end
         default: begin
            head_next = head_cur;
         end
      endcase
   end

endmodule

`default_nettype wire
